// ----- rtl/core/adagrad_sparse_update_top_defines.svh -----
// assertion macros shared by the adagrad update checker
`ifndef ADAGRAD_SPARSE_UPDATE_TOP_DEFINES_SVH
`define ADAGRAD_SPARSE_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/asu_pkg.sv -----
// types and constants of the adagrad sparse update block
package asu_pkg;

  // store geometry
  localparam int STORE_DEPTH_DEF = 4096;

  // field widths
  localparam int ROW_W      = 12;
  localparam int COL_W      = 12;
  localparam int GRAD_W     = 16;
  localparam int ROWS_W     = 13;
  localparam int OUT_W      = 14;
  localparam int MAG_W      = 16;
  localparam int PROD_W     = 25;
  localparam int ADDR_W     = 26;
  localparam int SQ_W       = 31;
  localparam int SUM_W      = 40;
  localparam int ROOT_W     = 20;
  localparam int QUO_W      = 13;
  localparam int STEP_W     = 5;

  // constants
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd64;
  localparam logic [QUO_W-1:0]  Q_ONE      = 13'd4096;
  localparam int ROOT_STEPS = 20;
  localparam int DIV_STEPS  = 13;

  // one input item
  typedef struct packed {
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic signed [GRAD_W-1:0] grad_value;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [OUT_W-1:0] scaled_grad;
    logic                    sum_saturated;
    logic                    address_error;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic mul;
    logic chk;
    logic sum;
    logic root_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic addr_err;
  } sts_t;

endpackage

// ----- rtl/core/asu_ram.sv -----
// generic single write port, single read port ram with registered read
module asu_ram #(
  parameter int WIDTH = asu_pkg::SUM_W,
  parameter int DEPTH = asu_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/asu_datapath.sv -----
// datapath: address, square sum store, bitwise root and restoring divider
module asu_datapath #(
  parameter int STORE_DEPTH = asu_pkg::STORE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  asu_pkg::cmd_t               cmd,
  output asu_pkg::sts_t               sts,
  input  asu_pkg::in_item_t           in_data,
  input  logic                        cfg_we,
  input  logic [asu_pkg::ROWS_W-1:0]  cfg_data,
  output asu_pkg::out_item_t          out_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  // configuration and clear sweep
  logic [asu_pkg::ROWS_W-1:0] rows_r;
  logic [AW-1:0]              clr_cnt_r;

  // captured item
  logic [asu_pkg::ROW_W-1:0]  row_r;
  logic [asu_pkg::COL_W-1:0]  col_r;
  logic [asu_pkg::MAG_W-1:0]  mag_r;
  logic                       neg_r;

  // address and square
  logic [asu_pkg::ADDR_W-1:0] addr_r;
  logic [asu_pkg::SQ_W-1:0]   sq_r;
  logic                       err_r;
  logic                       sat_r;

  // root and divider state
  logic [asu_pkg::SUM_W-1:0]  v_r;
  logic [asu_pkg::SUM_W-1:0]  res_r;
  logic [asu_pkg::SUM_W-1:0]  bit_r;
  logic [asu_pkg::ROOT_W-1:0] rem_r;
  logic [asu_pkg::QUO_W-1:0]  dbits_r;
  logic [asu_pkg::QUO_W-1:0]  q_r;

  asu_pkg::out_item_t         out_r;

  // combinational terms
  logic [asu_pkg::GRAD_W-1:0] g_u;
  logic [asu_pkg::MAG_W-1:0]  mag_in;
  logic [asu_pkg::PROD_W-1:0] prod;
  logic [asu_pkg::ADDR_W-1:0] addr_nxt;
  logic [31:0]                sq_full;
  logic [asu_pkg::SUM_W-1:0]  rdata;
  logic [asu_pkg::SUM_W:0]    sum_ext;
  logic [asu_pkg::SUM_W-1:0]  sum_new;
  logic [asu_pkg::SUM_W-1:0]  trial;
  logic                       root_ge;
  logic [asu_pkg::ROOT_W:0]   shifted;
  logic [asu_pkg::ROOT_W:0]   divisor;
  logic                       div_ge;
  logic [asu_pkg::QUO_W-1:0]  q_cl;
  logic [asu_pkg::OUT_W-1:0]  q_ext;
  logic [asu_pkg::OUT_W-1:0]  scaled;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [asu_pkg::SUM_W-1:0]  ram_wdata;

  // magnitude and sign of the incoming gradient
  assign g_u    = in_data.grad_value;
  assign mag_in = g_u[asu_pkg::GRAD_W-1] ? (~g_u + 16'd1) : g_u;

  // column-major address and squared gradient
  assign prod     = asu_pkg::PROD_W'(col_r) * asu_pkg::PROD_W'(rows_r);
  assign addr_nxt = {1'b0, prod} + asu_pkg::ADDR_W'(row_r);
  assign sq_full  = 32'(mag_r) * 32'(mag_r);

  // address range check
  assign sts.addr_err = (addr_r >= asu_pkg::ADDR_W'(STORE_DEPTH));
  assign sts.clr_last = (clr_cnt_r == AW'(STORE_DEPTH - 1));

  // saturating accumulate
  assign sum_ext = {1'b0, rdata} + (asu_pkg::SUM_W + 1)'(sq_r);
  assign sum_new = sum_ext[asu_pkg::SUM_W] ? '1 : sum_ext[asu_pkg::SUM_W-1:0];

  // one root step: one result bit per trial subtract
  assign trial   = res_r + bit_r;
  assign root_ge = (v_r >= trial);

  // one divider step: one quotient bit
  assign shifted = {rem_r, dbits_r[asu_pkg::QUO_W-1]};
  assign divisor = {1'b0, res_r[asu_pkg::ROOT_W-1:0]};
  assign div_ge  = (shifted >= divisor);

  // final quotient with zero-root and full-scale handling
  always_comb begin
    if (res_r[asu_pkg::ROOT_W-1:0] == '0) begin
      q_cl = '0;
    end else if (q_r > asu_pkg::Q_ONE) begin
      q_cl = asu_pkg::Q_ONE;
    end else begin
      q_cl = q_r;
    end
  end

  assign q_ext  = {1'b0, q_cl};
  assign scaled = neg_r ? (~q_ext + 14'd1) : q_ext;

  // store write mux: clear sweep or sum write-back
  assign ram_we    = cmd.clr | cmd.sum;
  assign ram_waddr = cmd.clr ? clr_cnt_r : addr_r[AW-1:0];
  assign ram_wdata = cmd.clr ? '0 : sum_new;

  asu_ram #(
    .WIDTH (asu_pkg::SUM_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.chk),
    .raddr (addr_r[AW-1:0]),
    .rdata (rdata)
  );

  // configuration register and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= asu_pkg::ROWS_RESET;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        rows_r <= cfg_data;
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= in_data.row_index;
      col_r <= in_data.col_index;
      mag_r <= mag_in;
      neg_r <= g_u[asu_pkg::GRAD_W-1];
    end
    if (cmd.mul) begin
      addr_r <= addr_nxt;
      sq_r   <= sq_full[asu_pkg::SQ_W-1:0];
    end
    if (cmd.chk) begin
      err_r <= sts.addr_err;
    end
    if (cmd.sum) begin
      sat_r <= sum_ext[asu_pkg::SUM_W];
      v_r   <= sum_new;
      res_r <= '0;
      bit_r <= asu_pkg::SUM_W'(1) << (asu_pkg::SUM_W - 2);
    end
    if (cmd.root_step) begin
      if (root_ge) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      rem_r   <= asu_pkg::ROOT_W'(mag_r >> 1);
      dbits_r <= {mag_r[0], {(asu_pkg::QUO_W-1){1'b0}}};
      q_r     <= '0;
    end
    if (cmd.div_step) begin
      rem_r   <= div_ge ? asu_pkg::ROOT_W'(shifted - divisor) : shifted[asu_pkg::ROOT_W-1:0];
      dbits_r <= dbits_r << 1;
      q_r     <= {q_r[asu_pkg::QUO_W-2:0], div_ge};
    end
    if (cmd.load_out) begin
      if (err_r) begin
        out_r.scaled_grad   <= '0;
        out_r.sum_saturated <= 1'b0;
        out_r.address_error <= 1'b1;
      end else begin
        out_r.scaled_grad   <= scaled;
        out_r.sum_saturated <= sat_r;
        out_r.address_error <= 1'b0;
      end
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/core/asu_ctrl.sv -----
// controller: sequences clear sweep, accumulate, root and divide steps
module asu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  asu_pkg::sts_t sts,
  output asu_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_SUM,
    ST_ROOT,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [asu_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.addr_err ? ST_DONE : ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + asu_pkg::STEP_W'(1);
        if (cnt_r == asu_pkg::STEP_W'(asu_pkg::ROOT_STEPS - 1)) begin
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + asu_pkg::STEP_W'(1);
        if (cnt_r == asu_pkg::STEP_W'(asu_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/adagrad_sparse_update_top.sv -----
// top level of the adagrad sparse update block
//
// Usage: each input item carries one nonzero gradient element (row, column,
// Q3.12 value). The block adds its square to the sum kept for that matrix
// position at column * rows_in_use + row and returns the gradient over the
// root of the new sum, with saturation and address flags.
// Channels: in_* and out_* are valid/ready; cfg_* writes rows_in_use and is
// always ready, to be used only while no item is in flight.
// Order: an in-range item passes the multiply, check, sum, root and divide
// steps; an address past the store goes from the check straight to the result.
// One item is worked on at a time: the 20-step bitwise root and the 13-step
// divider share one datapath, and the next item waits for the last result.
// Reset: every entry of the square sum store is swept to zero, one entry a
// cycle; in_ready stays low meanwhile, configuration is taken.
// Stall: a finished result waits in the output register; the next item is
// still accepted, and only its own result waits until the register drains.
module adagrad_sparse_update_top #(
  parameter int STORE_DEPTH = asu_pkg::STORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  asu_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output asu_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [asu_pkg::ROWS_W-1:0] cfg_data
);

  asu_pkg::cmd_t cmd;
  asu_pkg::sts_t sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // sequencer
  asu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and store
  asu_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

// ----- rtl/core/asu_checker.sv -----
// port-level checker of the adagrad sparse update block and its bind
`include "adagrad_sparse_update_top_defines.svh"

module asu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input asu_pkg::out_item_t out_data
);

  // a waiting result holds its value
  `ASU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  // one item at a time: no acceptance in the cycle after one
  `ASU_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item accepted while busy")

  // an address error result carries nothing else
  `ASU_ASSERT_NOW(a_err_zero, out_valid && out_data.address_error, out_data.scaled_grad == 14'sd0 && !out_data.sum_saturated, "address error result not cleared")

  // scaled gradient never exceeds one in magnitude
  `ASU_ASSERT_NOW(a_range, out_valid, out_data.scaled_grad <= 14'sd4096 && out_data.scaled_grad >= -14'sd4096, "scaled gradient out of range")

endmodule

bind adagrad_sparse_update_top asu_checker u_asu_checker (.*);
